/* rtl/core/bfdr_pkg.sv */
// ----------------------------------------------------------------------------
// bfdr_pkg
// Shared widths, codes and controller/datapath handoff types for the bounded
// queue with duplicate rejection.
// ----------------------------------------------------------------------------
package bfdr_pkg;

  localparam int MODE_W         = 2;
  localparam int VALUE_W        = 32;
  localparam int STATUS_W       = 3;
  localparam int COUNT_W        = 7;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 7;

  localparam int DEPTH_DEFAULT      = 64;
  localparam int DATA_WIDTH_DEFAULT = 32;

  localparam logic [CFG_DATA_W-1:0] MAX_ENTRIES_RESET = 7'd64;

  // Request modes.
  localparam logic [MODE_W-1:0] MODE_ENQ = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEQ = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLR = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUP   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NULL  = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ENTRIES = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REJECT_DUP  = 2'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                capture;     // latch the request payload
    logic                enq;         // write the word at the tail
    logic                deq;         // remove the head word
    logic                clr;         // empty the queue
    logic                scan_start;  // set up a duplicate scan from the head
    logic                scan_step;   // issue one scan read
    logic                head_load;   // take the new head word from memory
    logic                set_status;  // record status_code
    logic [STATUS_W-1:0] status_code;
    logic                result_load; // load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              word_zero;
    logic              full;
    logic              empty;
    logic              reject_dup;
    logic              scan_done;
    logic              dup_hit;
  } stat_t;

endpackage

/* rtl/core/bfdr_req_if.sv */
// ----------------------------------------------------------------------------
// bfdr_req_if
// Request channel: mode and data word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bfdr_req_if;

  logic                          valid;
  logic                          ready;
  logic [bfdr_pkg::MODE_W-1:0]   mode;
  logic [bfdr_pkg::VALUE_W-1:0]  data_value;

  modport source (output valid, output mode, output data_value, input ready);
  modport sink   (input valid, input mode, input data_value, output ready);

endinterface

/* rtl/core/bfdr_rsp_if.sv */
// ----------------------------------------------------------------------------
// bfdr_rsp_if
// Result channel: status, removed word, count, head and tail words.
// ----------------------------------------------------------------------------
interface bfdr_rsp_if;

  logic                           valid;
  logic                           ready;
  logic [bfdr_pkg::STATUS_W-1:0]  status;
  logic [bfdr_pkg::VALUE_W-1:0]   out_value;
  logic [bfdr_pkg::COUNT_W-1:0]   entry_count;
  logic [bfdr_pkg::VALUE_W-1:0]   head_value;
  logic [bfdr_pkg::VALUE_W-1:0]   tail_value;

  modport source (output valid, output status, output out_value, output entry_count,
                  output head_value, output tail_value, input ready);
  modport sink   (input valid, input status, input out_value, input entry_count,
                  input head_value, input tail_value, output ready);

endinterface

/* rtl/core/bfdr_cfg_if.sv */
// ----------------------------------------------------------------------------
// bfdr_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bfdr_cfg_if;

  logic                              valid;
  logic                              ready;
  logic [bfdr_pkg::CFG_INDEX_W-1:0]  index;
  logic [bfdr_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);

endinterface

/* rtl/core/bfdr_ram.sv */
// ----------------------------------------------------------------------------
// bfdr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bfdr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/bfdr_dp.sv */
// ----------------------------------------------------------------------------
// bfdr_dp
// Datapath: ring indices, count, cached head and tail words, duplicate scan,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module bfdr_dp #(
  parameter int DEPTH      = bfdr_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = bfdr_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  bfdr_pkg::cmd_t                   cmd,
  output bfdr_pkg::stat_t                  stat,
  input  logic [bfdr_pkg::MODE_W-1:0]      req_mode,
  input  logic [bfdr_pkg::VALUE_W-1:0]     req_data_value,
  input  logic                             cfg_we,
  input  logic [bfdr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bfdr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic [bfdr_pkg::STATUS_W-1:0]    rsp_status,
  output logic [bfdr_pkg::VALUE_W-1:0]     rsp_out_value,
  output logic [bfdr_pkg::COUNT_W-1:0]     rsp_entry_count,
  output logic [bfdr_pkg::VALUE_W-1:0]     rsp_head_value,
  output logic [bfdr_pkg::VALUE_W-1:0]     rsp_tail_value
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > bfdr_pkg::CFG_DATA_W) ? CW : bfdr_pkg::CFG_DATA_W;
  localparam int SW = (DATA_WIDTH < bfdr_pkg::VALUE_W) ? DATA_WIDTH : bfdr_pkg::VALUE_W;
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  logic [AW-1:0]                     head_idx;
  logic [AW-1:0]                     tail_idx;
  logic [CW-1:0]                     count;
  logic [bfdr_pkg::CFG_DATA_W-1:0]   max_entries;
  logic                              reject_dup;
  logic [bfdr_pkg::MODE_W-1:0]       mode;
  logic [SW-1:0]                     word;
  logic [SW-1:0]                     head_word;
  logic [SW-1:0]                     tail_word;
  logic [SW-1:0]                     removed;
  logic [bfdr_pkg::STATUS_W-1:0]     status;
  logic [AW-1:0]                     scan_ptr;
  logic [CW-1:0]                     scan_left;
  logic                              cmp_valid;
  logic                              hit;

  logic [AW-1:0] head_next;
  logic [AW-1:0] tail_next;
  logic [AW-1:0] scan_next;
  logic [AW-1:0] rd_addr;
  logic [SW-1:0] rd_data;
  logic [LW-1:0] limit;
  logic [LW-1:0] max_ext;
  logic [LW-1:0] depth_ext;

  assign head_next = (head_idx == LAST_SLOT) ? '0 : head_idx + 1'b1;
  assign tail_next = (tail_idx == LAST_SLOT) ? '0 : tail_idx + 1'b1;
  assign scan_next = (scan_ptr == LAST_SLOT) ? '0 : scan_ptr + 1'b1;

  // A dequeue reads the slot after the head so the new head word arrives
  // in the following cycle; a scan walks the held entries.
  assign rd_addr = cmd.scan_step ? scan_ptr : head_next;

  // A limit of zero or above the store depth means the whole store.
  assign max_ext   = LW'(max_entries);
  assign depth_ext = LW'(DEPTH);
  assign limit     = (max_ext == '0 || max_ext > depth_ext) ? depth_ext : max_ext;

  assign stat.mode       = mode;
  assign stat.word_zero  = (word == '0);
  assign stat.full       = (LW'(count) >= limit);
  assign stat.empty      = (count == '0);
  assign stat.reject_dup = reject_dup;
  assign stat.scan_done  = (scan_left == '0) && !cmp_valid;
  assign stat.dup_hit    = hit;

  bfdr_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.enq),
    .waddr (tail_idx),
    .wdata (word),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Control state: indices, count, configuration, scan pipeline flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_idx    <= '0;
      tail_idx    <= '0;
      count       <= '0;
      max_entries <= bfdr_pkg::MAX_ENTRIES_RESET;
      reject_dup  <= 1'b0;
      cmp_valid   <= 1'b0;
      scan_left   <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bfdr_pkg::REG_MAX_ENTRIES: max_entries <= cfg_data;
          bfdr_pkg::REG_REJECT_DUP:  reject_dup  <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.clr) begin
        head_idx <= '0;
        tail_idx <= '0;
        count    <= '0;
      end else if (cmd.enq) begin
        tail_idx <= tail_next;
        count    <= count + 1'b1;
      end else if (cmd.deq) begin
        head_idx <= head_next;
        count    <= count - 1'b1;
      end
      if (cmd.scan_start) begin
        scan_left <= count;
        cmp_valid <= 1'b0;
      end else if (cmd.scan_step) begin
        cmp_valid <= (scan_left != '0);
        if (scan_left != '0) begin
          scan_left <= scan_left - 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode    <= req_mode;
      word    <= req_data_value[SW-1:0];
      removed <= '0;
    end
    if (cmd.set_status) begin
      status <= cmd.status_code;
    end
    if (cmd.enq) begin
      tail_word <= word;
      if (count == '0) begin
        head_word <= word;
      end
    end
    if (cmd.deq) begin
      removed <= head_word;
    end
    if (cmd.head_load) begin
      head_word <= rd_data;
    end
    if (cmd.scan_start) begin
      scan_ptr <= head_idx;
      hit      <= 1'b0;
    end else if (cmd.scan_step) begin
      if (scan_left != '0) begin
        scan_ptr <= scan_next;
      end
      if (cmp_valid && rd_data == word) begin
        hit <= 1'b1;
      end
    end
    if (cmd.result_load) begin
      rsp_status      <= status;
      rsp_out_value   <= bfdr_pkg::VALUE_W'(removed);
      rsp_entry_count <= bfdr_pkg::COUNT_W'(count);
      rsp_head_value  <= (count == '0) ? '0 : bfdr_pkg::VALUE_W'(head_word);
      rsp_tail_value  <= (count == '0) ? '0 : bfdr_pkg::VALUE_W'(tail_word);
    end
  end

endmodule

/* rtl/core/bfdr_ctrl.sv */
// ----------------------------------------------------------------------------
// bfdr_ctrl
// Controller: sequences one request through decision, duplicate scan, head
// refill and the output register handoff.
// ----------------------------------------------------------------------------
module bfdr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  input  bfdr_pkg::stat_t stat,
  output bfdr_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_HEAD   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       rsp_valid_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.status_code = bfdr_pkg::ST_OK;
    state_next     = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.set_status = 1'b1;
        state_next     = S_FINISH;
        case (stat.mode)
          bfdr_pkg::MODE_ENQ: begin
            if (stat.word_zero) begin
              cmd.status_code = bfdr_pkg::ST_NULL;
            end else if (stat.full) begin
              cmd.status_code = bfdr_pkg::ST_FULL;
            end else if (stat.reject_dup && !stat.empty) begin
              cmd.scan_start = 1'b1;
              state_next     = S_SCAN;
            end else begin
              cmd.enq = 1'b1;
            end
          end
          bfdr_pkg::MODE_DEQ: begin
            if (stat.empty) begin
              cmd.status_code = bfdr_pkg::ST_EMPTY;
            end else begin
              cmd.deq    = 1'b1;
              state_next = S_HEAD;
            end
          end
          bfdr_pkg::MODE_CLR: begin
            cmd.clr = 1'b1;
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          if (stat.dup_hit) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = bfdr_pkg::ST_DUP;
          end else begin
            cmd.enq = 1'b1;
          end
          state_next = S_FINISH;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_HEAD: begin
        cmd.head_load = 1'b1;
        state_next    = S_FINISH;
      end
      S_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.result_load = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.result_load) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

/* rtl/core/bounded_fifo_dup_reject.sv */
// ----------------------------------------------------------------------------
// bounded_fifo_dup_reject
// Each request passes S_IDLE, S_DECIDE and S_FINISH; a dequeue adds S_HEAD to
// refill the head word, and an enqueue with duplicate rejection on and a
// nonempty queue adds S_SCAN, which walks every held entry first.
// Throughput: one request at a time; the next is taken once the result is
// loaded, while that result may still wait in the output register.
// Reset (rst, synchronous): queue empty, limit 64, duplicates allowed.
// ----------------------------------------------------------------------------
module bounded_fifo_dup_reject #(
  parameter int DEPTH      = bfdr_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = bfdr_pkg::DATA_WIDTH_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  bfdr_req_if.sink  req,
  bfdr_rsp_if.source rsp,
  bfdr_cfg_if.sink  cfg
);

  // The controller and datapath talk only through these two structs.
  bfdr_pkg::cmd_t  cmd;
  bfdr_pkg::stat_t stat;

  // Configuration writes are always taken. The user must send them only while
  // the queue is idle so they never disturb a request; the block does not check.
  assign cfg.ready = 1'b1;

  // The controller owns both handshakes. It takes a request only when it is
  // idle, and it hands the result to the output register once that register
  // is empty or being drained in the same cycle.
  bfdr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath holds the ring store, its indices and count, the cached
  // head and tail words, the duplicate scan and the result payload. The
  // head word is cached so a dequeue returns it at once, and refilled from
  // the store in the following cycle; the tail word is the last one written.
  bfdr_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .req_mode        (req.mode),
    .req_data_value  (req.data_value),
    .cfg_we          (cfg.valid && cfg.ready),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .rsp_status      (rsp.status),
    .rsp_out_value   (rsp.out_value),
    .rsp_entry_count (rsp.entry_count),
    .rsp_head_value  (rsp.head_value),
    .rsp_tail_value  (rsp.tail_value)
  );

endmodule
